// ----- design/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and helpers for the fixed-point ALU
// Opcodes, request and response beats, the side-band record that rides
// alongside the divider, and the 33-bit clamp helper.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_CMP      = 4'd10
  } alu_op_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               saturated;
    logic               divide_by_zero;
  } alu_rsp_t;

  // Clamped value with its saturation flag
  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat_val_t;

  // Everything except the multiply and divide results, carried to the end
  typedef struct packed {
    logic [3:0]         op;
    logic               less;
    logic               equal;
    logic               greater;
    logic signed [31:0] value;
    logic               sat;
    logic               dz;
    logic               div_neg;
  } side_t;

  function automatic sat_val_t clamp33(input logic signed [32:0] v);
    sat_val_t r;
    if (v[32] != v[31]) begin
      r.sat   = 1'b1;
      r.value = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r.sat   = 1'b0;
      r.value = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/fpa_div_stage.sv -----
// ----------------------------------------------------------------------------
// fpa_div_stage: one restoring division step
// Shift the next dividend bit into the partial remainder, subtract the
// divisor when it fits, and shift the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic [31:0]   rem_in,
  input  logic [NW-1:0] acc_in,
  input  logic [31:0]   den_in,
  output logic [31:0]   rem_q,
  output logic [NW-1:0] acc_q,
  output logic [31:0]   den_q
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  always_comb begin
    trial = {rem_in, acc_in[NW-1]};
    diff  = trial - {1'b0, den_in};
    fits  = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    rem_q <= fits ? diff[31:0] : trial[31:0];
    acc_q <= {acc_in[NW-2:0], fits};
    den_q <= den_in;
  end

endmodule

// ----- design/fpa_divider.sv -----
// ----------------------------------------------------------------------------
// fpa_divider: pipelined unsigned long divider
// NW restoring steps, one per register stage, between the operands going in
// and the quotient and remainder coming out.
// ----------------------------------------------------------------------------
module fpa_divider #(
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic [NW-1:0] quo,
  output logic [31:0]   rem,
  output logic [31:0]   den_out
);

  logic [31:0]   rem_s [NW+1];
  logic [NW-1:0] acc_s [NW+1];
  logic [31:0]   den_s [NW+1];

  assign rem_s[0] = '0;
  assign acc_s[0] = num;
  assign den_s[0] = den;

  for (genvar k = 0; k < NW; k++) begin : g_step
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk    (clk),
      .rem_in (rem_s[k]),
      .acc_in (acc_s[k]),
      .den_in (den_s[k]),
      .rem_q  (rem_s[k+1]),
      .acc_q  (acc_s[k+1]),
      .den_q  (den_s[k+1])
    );
  end

  assign quo     = acc_s[NW];
  assign rem     = rem_s[NW];
  assign den_out = den_s[NW];

endmodule

// ----- design/fpa_mul.sv -----
// ----------------------------------------------------------------------------
// fpa_mul: pipelined fixed-point multiply
// Four stages: product, magnitude, round half away from zero, clamp.
// ----------------------------------------------------------------------------
module fpa_mul #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output fpa_pkg::sat_val_t  res
);
  import fpa_pkg::*;

  localparam int RW = 64 - FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  logic signed [63:0] prod;
  logic [63:0]        mag;
  logic               neg2;
  logic [RW-1:0]      rnd;
  logic               neg3;
  logic [63:0]        rnd_sum;

  assign rnd_sum = mag + HALF;

  always_ff @(posedge clk) begin
    prod <= a * b;
    neg2 <= prod[63];
    mag  <= prod[63] ? 64'(-prod) : 64'(prod);
    neg3 <= neg2;
    rnd  <= rnd_sum[63:FRAC_BITS];
    if (neg3) begin
      if (rnd > RW'(64'h8000_0000)) begin
        res <= '{value: S32_MIN, sat: 1'b1};
      end else begin
        res <= '{value: -(rnd[31:0]), sat: 1'b0};
      end
    end else begin
      if (rnd > RW'(64'h7fff_ffff)) begin
        res <= '{value: S32_MAX, sat: 1'b1};
      end else begin
        res <= '{value: rnd[31:0], sat: 1'b0};
      end
    end
  end

endmodule

// ----- design/fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu: signed 32-bit fixed-point ALU
// Add, subtract, multiply, divide, step, min/max and integer conversion
// with saturation and compare flags, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request beat on req and raise start; the beat is taken at any
//   clock edge where start is high. busy is held low: a new beat can be
//   sent in every cycle and each one is independent of the others.
//   Each result appears on result for exactly one cycle, marked by done,
//   in the same order as the requests.
// Timing: the path from accept to the done cycle is the same for every
//   operation. Throughput is one beat per cycle. The path is set by the
//   divider: one restoring step per stage over 32 + FRAC_BITS quotient bits,
//   plus input, setup, rounding and output stages.
// Reset clears the valid pipeline, so no done pulse follows a reset until
//   new beats are sent. The receiver cannot stall, so results simply
//   advance one stage each cycle and leave on their done cycle.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::alu_req_t req,
  output logic              done,
  output fpa_pkg::alu_rsp_t result
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  // Valid bits travel alongside every stage
  logic [NW+2:0] vpipe;

  // Input register
  alu_req_t req_q;

  // Setup stage
  side_t         side_next;
  side_t         side_q;
  logic [NW-1:0] num_q;
  logic [31:0]   den_q;
  logic [31:0]   mag_a;
  logic [31:0]   mag_b;
  sat_val_t      sv;
  logic signed [63:0] wide;

  // Delay lines to line up with the divider
  side_t    side_dly [NW+1];
  sat_val_t mul_res;
  sat_val_t mul_dly [NW-2];

  // Divider and rounding
  logic [NW-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   den_out;
  logic [NW:0]   q_rnd;

  // Output stage
  side_t    so;
  sat_val_t div_res;
  alu_rsp_t result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[NW+1:0], start};
      done  <= vpipe[NW+2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_q <= req;
    end
  end

  // Setup: cheap operations, compare flags, divider operands
  always_comb begin
    mag_a = req_q.operand_a[31] ? 32'(-req_q.operand_a) : 32'(req_q.operand_a);
    mag_b = req_q.operand_b[31] ? 32'(-req_q.operand_b) : 32'(req_q.operand_b);
    wide  = 64'(req_q.operand_a) <<< FRAC_BITS;

    side_next         = '0;
    side_next.op      = req_q.req_type;
    side_next.less    = req_q.operand_a <  req_q.operand_b;
    side_next.equal   = req_q.operand_a == req_q.operand_b;
    side_next.greater = req_q.operand_a >  req_q.operand_b;
    side_next.div_neg = req_q.operand_a[31] ^ req_q.operand_b[31];
    sv = '0;

    case (req_q.req_type)
      OP_ADD: begin
        sv = clamp33(33'(req_q.operand_a) + 33'(req_q.operand_b));
      end
      OP_SUB: begin
        sv = clamp33(33'(req_q.operand_a) - 33'(req_q.operand_b));
      end
      OP_INC: begin
        sv = clamp33(33'(req_q.operand_a) + 33'sd1);
      end
      OP_DEC: begin
        sv = clamp33(33'(req_q.operand_a) - 33'sd1);
      end
      OP_MIN: begin
        sv.value = side_next.less ? req_q.operand_a : req_q.operand_b;
      end
      OP_MAX: begin
        sv.value = side_next.greater ? req_q.operand_a : req_q.operand_b;
      end
      OP_TO_INT: begin
        sv.value = req_q.operand_a >>> FRAC_BITS;
      end
      OP_FROM_INT: begin
        if (wide > 64'(S32_MAX)) begin
          sv = '{value: S32_MAX, sat: 1'b1};
        end else if (wide < 64'(S32_MIN)) begin
          sv = '{value: S32_MIN, sat: 1'b1};
        end else begin
          sv.value = wide[31:0];
        end
      end
      OP_DIV: begin
        // Zero divisor: saturate by the dividend's sign, zero for 0/0
        if (req_q.operand_b == 32'sd0) begin
          side_next.dz = 1'b1;
          if (req_q.operand_a > 32'sd0) begin
            sv = '{value: S32_MAX, sat: 1'b1};
          end else if (req_q.operand_a < 32'sd0) begin
            sv = '{value: S32_MIN, sat: 1'b1};
          end
        end
      end
      default: begin
        sv = '0;
      end
    endcase

    side_next.value = sv.value;
    side_next.sat   = sv.sat;
  end

  always_ff @(posedge clk) begin
    side_q <= side_next;
    num_q  <= NW'(mag_a) << FRAC_BITS;
    den_q  <= mag_b;
  end

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (req_q.operand_a),
    .b   (req_q.operand_b),
    .res (mul_res)
  );

  fpa_divider #(.NW(NW)) u_div (
    .clk     (clk),
    .num     (num_q),
    .den     (den_q),
    .quo     (quo),
    .rem     (rem),
    .den_out (den_out)
  );

  // Hold side-band and multiply results until the quotient is rounded
  always_ff @(posedge clk) begin
    side_dly[0] <= side_q;
    for (int k = 1; k <= NW; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
    mul_dly[0] <= mul_res;
    for (int k = 1; k < NW - 2; k++) begin
      mul_dly[k] <= mul_dly[k-1];
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor
  always_ff @(posedge clk) begin
    q_rnd <= {1'b0, quo} + (NW+1)'({rem, 1'b0} >= {1'b0, den_out});
  end

  // Output: sign and clamp the quotient, then pick the result
  always_comb begin
    so = side_dly[NW];
    if (so.div_neg) begin
      if (q_rnd > (NW+1)'(64'h8000_0000)) begin
        div_res = '{value: S32_MIN, sat: 1'b1};
      end else begin
        div_res = '{value: -(q_rnd[31:0]), sat: 1'b0};
      end
    end else begin
      if (q_rnd > (NW+1)'(64'h7fff_ffff)) begin
        div_res = '{value: S32_MAX, sat: 1'b1};
      end else begin
        div_res = '{value: q_rnd[31:0], sat: 1'b0};
      end
    end

    result_next.a_less         = so.less;
    result_next.a_equal        = so.equal;
    result_next.a_greater      = so.greater;
    result_next.divide_by_zero = so.dz;
    if (so.op == OP_MUL) begin
      result_next.result_value = mul_dly[NW-3].value;
      result_next.saturated    = mul_dly[NW-3].sat;
    end else if (so.op == OP_DIV && !so.dz) begin
      result_next.result_value = div_res.value;
      result_next.saturated    = div_res.sat;
    end else begin
      result_next.result_value = so.value;
      result_next.saturated    = so.sat;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the fixed-point ALU
// Drives directed and random operation beats with bursty gaps, predicts
// every result with exact integer arithmetic and checks each done beat
// against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fpa_pkg::*;

  localparam int FB      = 8;
  localparam int LATENCY = FB + 35;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  alu_req_t req;
  logic     done;
  alu_rsp_t result;

  alu_rsp_t expected_rsps[$];
  int       mismatches;

  fixed_point_alu #(.FRAC_BITS(FB)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .result(result)
  );

  // 10-unit clock period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamp a wide value to the signed 32-bit range and flag it
  function automatic logic signed [31:0] sat32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Expected response for one beat; exact integer arithmetic throughout
  function automatic alu_rsp_t alu_predict(input alu_req_t r);
    alu_rsp_t    o;
    longint      a, b, p, res;
    logic [63:0] m, num, den, q, rm;
    logic        sat, dz;
    a   = r.operand_a;
    b   = r.operand_b;
    res = 0;
    sat = 1'b0;
    dz  = 1'b0;
    case (r.req_type)
      OP_ADD: res = sat32(a + b, sat);
      OP_SUB: res = sat32(a - b, sat);
      OP_MUL: begin
        p   = a * b;
        m   = (p < 0) ? -p : p;
        m   = (m + (64'd1 << (FB - 1))) >> FB;
        res = sat32((p < 0) ? -longint'(m) : longint'(m), sat);
      end
      OP_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
          if (a > 0) begin
            res = S32_MAX;
            sat = 1'b1;
          end else if (a < 0) begin
            res = S32_MIN;
            sat = 1'b1;
          end
        end else begin
          num = ((a < 0) ? -a : a) << FB;
          den = (b < 0) ? -b : b;
          q   = num / den;
          rm  = num % den;
          if (rm >= den - rm) q++;
          res = sat32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), sat);
        end
      end
      OP_INC:      res = sat32(a + 1, sat);
      OP_DEC:      res = sat32(a - 1, sat);
      OP_MIN:      res = (a < b) ? a : b;
      OP_MAX:      res = (a > b) ? a : b;
      OP_TO_INT:   res = a >>> FB;
      OP_FROM_INT: res = sat32(a * (64'sd1 <<< FB), sat);
      default:     res = 0;
    endcase
    o.result_value   = res[31:0];
    o.a_less         = a < b;
    o.a_equal        = a == b;
    o.a_greater      = a > b;
    o.saturated      = sat;
    o.divide_by_zero = dz;
    return o;
  endfunction

  // Send one beat and hold it until accepted; start stays high for the next beat
  task automatic send_beat(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    alu_req_t r;
    r.req_type  = op;
    r.operand_a = a;
    r.operand_b = b;
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_rsps.push_back(alu_predict(r));
    @(negedge clk);
  endtask

  // Drop start and hold the sender idle for a random gap
  task automatic idle_gap(input int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random operand biased toward edge values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7, 0))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(1023, 0) - 512;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_beat(OP_ADD, 32'h7fff_ffff, 32'd1);
    send_beat(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_SUB, 32'h8000_0000, 32'd1);
    send_beat(OP_SUB, 32'h7fff_ffff, 32'hffff_ffff);
    send_beat(OP_MUL, 32'h0000_0180, 32'h0000_0080);
    send_beat(OP_MUL, 32'hffff_ff80, 32'h0000_0001);
    send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(OP_MUL, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OP_DIV, 32'h0000_0100, 32'h0000_0300);
    send_beat(OP_DIV, 32'hffff_ff00, 32'h0000_0200);
    send_beat(OP_DIV, 32'h0000_0100, 32'd0);
    send_beat(OP_DIV, 32'hffff_ffff, 32'd0);
    send_beat(OP_DIV, 32'd0, 32'd0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_INC, 32'h7fff_ffff, 32'd5);
    send_beat(OP_DEC, 32'h8000_0000, 32'd5);
    send_beat(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OP_TO_INT, 32'hffff_ff01, 32'd0);
    send_beat(OP_TO_INT, 32'h7fff_ffff, 32'd0);
    send_beat(OP_FROM_INT, 32'h0080_0000, 32'd0);
    send_beat(OP_FROM_INT, 32'hff7f_ffff, 32'd0);
    send_beat(OP_CMP, 32'h1234_5678, 32'h1234_5678);
    send_beat(4'd11, 32'h0000_0005, 32'h0000_0009);
    send_beat(4'd15, 32'hffff_ffff, 32'hffff_fffe);
  endtask

  // Bursts of random beats with random gaps; some bursts run back to back
  task automatic test_random(input int count);
    int n;
    int burst;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(40, 1);
      while (burst > 0 && n < count) begin
        send_beat(4'($urandom_range(15, 0)), pick_operand(), pick_operand());
        n++;
        burst--;
      end
      if ($urandom_range(3, 0) != 0) idle_gap(12);
    end
  endtask

  // Let the pipeline run dry before resuming
  task automatic test_drain_pause();
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    test_random(100);
  endtask

  // Compare each done beat against the oldest prediction
  always @(posedge clk) begin
    alu_rsp_t exp_rsp;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (result !== exp_rsp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp val %h l%b e%b g%b s%b z%b, got val %h l%b e%b g%b s%b z%b",
              exp_rsp.result_value, exp_rsp.a_less, exp_rsp.a_equal, exp_rsp.a_greater,
              exp_rsp.saturated, exp_rsp.divide_by_zero, result.result_value,
              result.a_less, result.a_equal, result.a_greater, result.saturated,
              result.divide_by_zero);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    test_drain_pause();
    test_random(500);
    start <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- fixed_point_alu.f -----
design/fpa_pkg.sv
design/fpa_div_stage.sv
design/fpa_divider.sv
design/fpa_mul.sv
design/fixed_point_alu.sv
test/tb_top.sv
